FILE: rtl/scfc_pkg.sv
// Shared types, constants and the CRC-8 byte update for the sensor frame CRC checker.
`default_nettype none

package scfc_pkg;

    // CRC-8 settings: polynomial x^8 + x^5 + x^4 + 1, start value all ones, MSB first.
    localparam logic [7:0] CRC_POLY    = 8'h31;
    localparam logic [7:0] CRC_INIT    = 8'hFF;
    localparam logic [7:0] CRC_TOP_BIT = 8'h80;

    // Frame status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TEMP_BAD  = 2'd1;
    localparam logic [1:0] STATUS_HUMID_BAD = 2'd2;

    // Byte positions within the six-byte reply.
    localparam logic [2:0] POS_TEMP_HI  = 3'd0;
    localparam logic [2:0] POS_TEMP_LO  = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_HI   = 3'd3;
    localparam logic [2:0] POS_HUM_LO   = 3'd4;
    localparam logic [2:0] POS_HUM_CRC  = 3'd5;

    // One finished measurement.
    typedef struct packed {
        logic [1:0]  frame_status;
        logic [15:0] raw_humidity;
        logic [15:0] raw_temperature;
    } t_result;

    // Width of the packed result padded to whole bytes.
    localparam int RESULT_BITS = $bits(t_result);
    localparam int RESULT_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

    // Bytewise CRC-8 update, unrolled over the eight bits of the byte.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP_BIT) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/scfc_in_stage.sv
// Input register stage that holds one received byte and its frame-start flag.
`default_nettype none

module scfc_in_stage
    import scfc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_start,
    input  wire logic       i_advance,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_start
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_start;

    // Take a new word whenever the held one is empty or is being consumed.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte  <= i_byte;
            r_start <= i_start;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_start = r_start;

endmodule

`default_nettype wire

FILE: rtl/scfc_frame_core.sv
// Reply tracking: byte position, running CRC, captured words and the status decision.
`default_nettype none

module scfc_frame_core
    import scfc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_skip_crc,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_start,
    input  wire logic       i_advance,
    output logic            o_last,
    output t_result         o_result
);

    logic [2:0]  r_pos;
    logic [7:0]  r_crc;
    logic [15:0] r_temp;
    logic [7:0]  r_hum_hi;
    logic [7:0]  r_hum_lo;
    logic        r_temp_bad;

    logic [2:0]  n_pos;
    logic [7:0]  n_crc;
    logic [15:0] n_temp;
    logic [7:0]  n_hum_hi;
    logic [7:0]  n_hum_lo;
    logic        n_temp_bad;

    logic        restart;
    logic [2:0]  pos_eff;
    logic [7:0]  crc_base;
    logic        temp_bad_base;
    logic [7:0]  crc_next;

    // A frame-start flag or an out-of-range position restarts the reply.
    assign restart       = i_start || (r_pos > POS_HUM_CRC);
    assign pos_eff       = restart ? POS_TEMP_HI : r_pos;
    assign crc_base      = restart ? CRC_INIT : r_crc;
    assign temp_bad_base = restart ? 1'b0 : r_temp_bad;
    assign crc_next      = crc8_update(crc_base, i_byte);

    // Next state for the byte at hand.
    always_comb begin
        n_pos      = pos_eff + 3'd1;
        n_crc      = crc_base;
        n_temp     = r_temp;
        n_hum_hi   = r_hum_hi;
        n_hum_lo   = r_hum_lo;
        n_temp_bad = temp_bad_base;
        case (pos_eff)
            POS_TEMP_HI: begin
                n_temp = {i_byte, 8'h00};
                n_crc  = crc_next;
            end
            POS_TEMP_LO: begin
                n_temp = {r_temp[15:8], i_byte};
                n_crc  = crc_next;
            end
            POS_TEMP_CRC: begin
                n_temp_bad = (crc_base != i_byte);
                n_crc      = CRC_INIT;
            end
            POS_HUM_HI: begin
                n_hum_hi = i_byte;
                n_crc    = crc_next;
            end
            POS_HUM_LO: begin
                n_hum_lo = i_byte;
                n_crc    = crc_next;
            end
            default: begin
                n_pos      = POS_TEMP_HI;
                n_crc      = CRC_INIT;
                n_temp_bad = 1'b0;
            end
        endcase
    end

    // The humidity CRC byte closes the reply and produces a result.
    assign o_last = (pos_eff == POS_HUM_CRC);

    always_comb begin
        o_result.raw_temperature = r_temp;
        o_result.raw_humidity    = {r_hum_hi, r_hum_lo};
        if (i_skip_crc) begin
            o_result.frame_status = STATUS_OK;
        end else if (temp_bad_base) begin
            o_result.frame_status = STATUS_TEMP_BAD;
        end else if (crc_base != i_byte) begin
            o_result.frame_status = STATUS_HUMID_BAD;
        end else begin
            o_result.frame_status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_TEMP_HI;
            r_crc      <= CRC_INIT;
            r_temp     <= 16'h0000;
            r_hum_hi   <= 8'h00;
            r_hum_lo   <= 8'h00;
            r_temp_bad <= 1'b0;
        end else if (i_advance) begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_temp     <= n_temp;
            r_hum_hi   <= n_hum_hi;
            r_hum_lo   <= n_hum_lo;
            r_temp_bad <= n_temp_bad;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/scfc_out_stage.sv
// Result register that holds one finished measurement until the consumer takes it.
`default_nettype none

module scfc_out_stage
    import scfc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_load,
    input  wire t_result  i_result,
    output logic          o_free,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_result       o_result
);

    logic    r_valid;
    t_result r_result;

    // The register can take a new result when empty or when its word leaves now.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: rtl/sensor_frame_crc_checker.sv
// Top level of the sensor frame CRC checker.
`default_nettype none

// Checks six-byte measurement replies (temperature high, low, CRC, humidity
// high, low, CRC) with CRC-8, polynomial 0x31, start value 0xFF, MSB first.
// One byte word is taken per clock unless the output register stalls the
// input; a byte passes an input register and combinational CRC and position
// logic, and on the last byte of a reply the result lands in an output
// register, so unstalled bytes may stream at one per cycle. The output
// register is the only stall point: a full output register whose word is not
// taken holds back the closing byte of the next reply and every byte behind
// it. A tuser of 1 marks a byte as the first of a reply and drops any
// partial one. With the skip register set the status is always ok; raw
// words are delivered as received whatever the status. Status: 0 ok, 1
// temperature CRC bad (takes precedence), 2 humidity CRC bad.
module sensor_frame_crc_checker
    import scfc_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration write: bit 0 = skip_crc_check.
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic                         i_cfg_data,
    // Byte stream in.
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] data_byte
    input  wire logic [7:0]                   s_axis_tdata,
    // [0] frame_start
    input  wire logic                         s_axis_tuser,
    // Result stream out.
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [15:0] raw_temperature, [31:16] raw_humidity, [33:32] frame_status, rest zero
    output logic [RESULT_TDATA_BITS-1:0]      m_axis_tdata
);

    logic       r_skip_crc;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_start;
    logic       advance;
    logic       is_last;
    logic       out_free;
    t_result    core_result;
    t_result    out_result;

    // Configuration register, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_crc <= 1'b0;
        end else if (i_cfg_valid) begin
            r_skip_crc <= i_cfg_data;
        end
    end

    scfc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_byte    (s_axis_tdata),
        .i_start   (s_axis_tuser),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte),
        .o_start   (in_start)
    );

    // A held byte moves on unless it closes a reply and the output is full.
    assign advance = in_valid && (!is_last || out_free);

    scfc_frame_core u_frame_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_skip_crc (r_skip_crc),
        .i_byte     (in_byte),
        .i_start    (in_start),
        .i_advance  (advance),
        .o_last     (is_last),
        .o_result   (core_result)
    );

    scfc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && is_last),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {{(RESULT_TDATA_BITS - RESULT_BITS){1'b0}}, out_result};

endmodule

`default_nettype wire
